// ===== hw/rtl/iprl_pkg.sv =====
`default_nettype none

package iprl_pkg;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_FORWARD  = 3'd2;
    localparam logic [2:0] ST_TTL_DROP = 3'd3;
    localparam logic [2:0] ST_NO_ROUTE = 3'd4;

    localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

    typedef struct packed {
        logic        cmd;
        logic [31:0] net_prefix;
        logic [5:0]  mask_len;
        logic [31:0] gateway_addr;
        logic        gateway_valid;
        logic [2:0]  interface_index;
        logic [31:0] dest_addr;
        logic [7:0]  ttl_in;
    } route_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  out_interface;
        logic [31:0] next_hop_addr;
        logic [7:0]  ttl_out;
    } route_rsp_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic [31:0] gateway;
        logic        has_gateway;
        logic [2:0]  port;
    } route_entry_t;

    typedef struct packed {
        logic capture;
        logic issue;
        logic finish;
    } iprl_cmd_t;

    typedef struct packed {
        logic scan_skip;
        logic scan_last;
        logic out_free;
    } iprl_sts_t;

    // Network mask with the given number of leading ones (length is at most 32).
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] mask;
        if (len == 6'd0)
        begin
            mask = 32'h0;
        end
        else
        begin
            mask = 32'hFFFF_FFFF << (MAX_PREFIX_LEN - len);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipv4_route_lookup_unit.sv =====
`default_nettype none

// IPv4 forwarding table with longest-prefix lookup. An add request stores or replaces a route
// and answers stored or table full; a lookup request answers forwarded (with interface, next
// hop and decremented TTL), TTL expired or no route. Each request reads the stored routes one
// per cycle from the table memory, and an expired lookup or a request to an empty table reads
// none. A response still waiting in the output register holds the next one back until it is
// taken. Requests are handled one at a time, and a new one is accepted while the previous
// response still waits.
module ipv4_route_lookup_unit #(
    parameter int ROUTE_ENTRIES = 64,
    parameter int NUM_PORTS     = 8
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  iprl_pkg::route_req_t req_data,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output iprl_pkg::route_rsp_t rsp_data
);
    import iprl_pkg::*;

    iprl_cmd_t ctrl;
    iprl_sts_t sts;

    iprl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .ctrl      (ctrl),
        .sts       (sts)
    );

    iprl_datapath #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .NUM_PORTS     (NUM_PORTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_data  (rsp_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/iprl_datapath.sv =====
`default_nettype none

module iprl_datapath #(
    parameter int ROUTE_ENTRIES = 64,
    parameter int NUM_PORTS     = 8
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  iprl_pkg::route_req_t req_data,
    output iprl_pkg::route_rsp_t rsp_data,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    input  iprl_pkg::iprl_cmd_t  ctrl,
    output iprl_pkg::iprl_sts_t  sts
);
    import iprl_pkg::*;

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
    localparam int PORT_W = 9;

    route_entry_t route_mem [ROUTE_ENTRIES];
    route_entry_t rd_entry_reg;

    logic         cmd_reg, cmd_next;
    route_entry_t new_entry_reg, new_entry_next;
    logic [31:0]  dst_reg, dst_next;
    logic [7:0]   ttl_reg, ttl_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_slot_reg, hit_slot_next;
    logic             best_found_reg, best_found_next;
    logic [5:0]       best_len_reg, best_len_next;
    logic [2:0]       best_port_reg, best_port_next;
    logic [31:0]      best_hop_reg, best_hop_next;

    logic       rsp_valid_reg, rsp_valid_next;
    route_rsp_t rsp_data_reg, rsp_data_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [5:0]       len_sat;
    logic [PORT_W-1:0] port_acc;

    // Interface number reduced modulo the port count by repeated subtraction.
    always_comb
    begin
        port_acc = {{(PORT_W - 3){1'b0}}, req_data.interface_index};
        for (int k = 0; k < 8; k++)
        begin
            if (port_acc >= PORT_W'(NUM_PORTS))
            begin
                port_acc = port_acc - PORT_W'(NUM_PORTS);
            end
        end
    end

    assign len_sat = (req_data.mask_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                           : req_data.mask_len;

    always_comb
    begin
        cmd_next        = cmd_reg;
        new_entry_next  = new_entry_reg;
        dst_next        = dst_reg;
        ttl_next        = ttl_reg;
        idx_next        = idx_reg;
        rd_idx_next     = rd_idx_reg;
        rd_valid_next   = ctrl.issue;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        best_found_next = best_found_reg;
        best_len_next   = best_len_reg;
        best_port_next  = best_port_reg;
        best_hop_next   = best_hop_reg;
        rsp_valid_next  = rsp_valid_reg & ~rsp_ready;
        rsp_data_next   = rsp_data_reg;
        wr_en           = 1'b0;
        wr_addr         = hit_slot_reg;

        if (ctrl.capture)
        begin
            cmd_next                   = req_data.cmd;
            new_entry_next.length      = len_sat;
            new_entry_next.prefix      = req_data.net_prefix & len_mask(len_sat);
            new_entry_next.has_gateway = req_data.gateway_valid;
            new_entry_next.gateway     = req_data.gateway_valid ? req_data.gateway_addr
                                                                : 32'h0;
            new_entry_next.port        = port_acc[2:0];
            dst_next                   = req_data.dest_addr;
            ttl_next                   = req_data.ttl_in;
            idx_next                   = '0;
            hit_next                   = 1'b0;
            best_found_next            = 1'b0;
        end

        if (ctrl.issue)
        begin
            idx_next    = IDX_W'(idx_reg + 1'b1);
            rd_idx_next = idx_reg;
        end

        if (rd_valid_reg)
        begin
            if (cmd_reg == CMD_ADD)
            begin
                // The first stored entry with the same prefix and length is replaced.
                if (!hit_reg && rd_entry_reg.length == new_entry_reg.length
                    && rd_entry_reg.prefix == new_entry_reg.prefix)
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = rd_idx_reg;
                end
            end
            else
            begin
                // A strictly longer match wins, so the earliest of equal lengths is kept.
                if ((dst_reg & len_mask(rd_entry_reg.length)) == rd_entry_reg.prefix
                    && (!best_found_reg || rd_entry_reg.length > best_len_reg))
                begin
                    best_found_next = 1'b1;
                    best_len_next   = rd_entry_reg.length;
                    best_port_next  = rd_entry_reg.port;
                    best_hop_next   = rd_entry_reg.has_gateway ? rd_entry_reg.gateway
                                                               : dst_reg;
                end
            end
        end

        if (ctrl.finish)
        begin
            rsp_valid_next              = 1'b1;
            rsp_data_next.out_interface = 3'd0;
            rsp_data_next.next_hop_addr = 32'h0;
            rsp_data_next.ttl_out       = 8'd0;
            if (cmd_reg == CMD_ADD)
            begin
                if (hit_reg)
                begin
                    wr_en                = 1'b1;
                    wr_addr              = hit_slot_reg;
                    rsp_data_next.status = ST_STORED;
                end
                else if (cnt_reg < CNT_W'(ROUTE_ENTRIES))
                begin
                    // Routes are never removed, so the used slots are always the lowest ones.
                    wr_en                = 1'b1;
                    wr_addr              = cnt_reg[IDX_W-1:0];
                    cnt_next             = CNT_W'(cnt_reg + 1'b1);
                    rsp_data_next.status = ST_STORED;
                end
                else
                begin
                    rsp_data_next.status = ST_FULL;
                end
            end
            else if (ttl_reg <= 8'd1)
            begin
                rsp_data_next.status = ST_TTL_DROP;
            end
            else if (best_found_reg)
            begin
                rsp_data_next.status        = ST_FORWARD;
                rsp_data_next.out_interface = best_port_reg;
                rsp_data_next.next_hop_addr = best_hop_reg;
                rsp_data_next.ttl_out       = ttl_reg - 8'd1;
            end
            else
            begin
                rsp_data_next.status = ST_NO_ROUTE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            route_mem[wr_addr] <= new_entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            rd_entry_reg <= route_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            rd_valid_reg   <= rd_valid_next;
            cnt_reg        <= cnt_next;
            hit_reg        <= hit_next;
            best_found_reg <= best_found_next;
            rsp_valid_reg  <= rsp_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        new_entry_reg <= new_entry_next;
        dst_reg       <= dst_next;
        ttl_reg       <= ttl_next;
        rd_idx_reg    <= rd_idx_next;
        hit_slot_reg  <= hit_slot_next;
        best_len_reg  <= best_len_next;
        best_port_reg <= best_port_next;
        best_hop_reg  <= best_hop_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign sts.scan_skip = (cnt_reg == '0) || (cmd_reg == CMD_LOOKUP && ttl_reg <= 8'd1);
    assign sts.scan_last = (CNT_W'(idx_reg) == CNT_W'(cnt_reg - 1'b1));
    assign sts.out_free  = ~rsp_valid_reg | rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ROUTE_ENTRIES))
        else $error("route count exceeds table size");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.issue |-> CNT_W'(idx_reg) < cnt_reg)
        else $error("table read beyond stored routes");

    a_add_status: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish && cmd_reg == CMD_ADD |=>
            rsp_valid_reg && (rsp_data_reg.status == ST_STORED
                              || rsp_data_reg.status == ST_FULL))
        else $error("add request gave a lookup status");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.status == ST_FULL |-> cnt_reg == CNT_W'(ROUTE_ENTRIES))
        else $error("table full reported with free slots");

    a_forward_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.status == ST_FORWARD |-> rsp_data_reg.ttl_out != 8'd0)
        else $error("forwarded datagram with zero TTL");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/iprl_ctrl.sv =====
`default_nettype none

module iprl_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    output iprl_pkg::iprl_cmd_t ctrl,
    input  iprl_pkg::iprl_sts_t sts
);
    import iprl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        req_ready    = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.issue   = 1'b0;
        ctrl.finish  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready    = 1'b1;
                ctrl.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_skip)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.issue = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            // The last entry read is still being compared.
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
